>>> sv/dwta_pkg.sv
package dwta_pkg;

  // Filter geometry.
  localparam int unsigned TAP_COUNT    = 9;
  localparam int unsigned WIN_DEPTH    = TAP_COUNT + 1;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned TAP_W        = 18;
  localparam int unsigned TAPS_PER_REG = 3;
  localparam int unsigned TAP_REGS     = 3;
  localparam int unsigned TAP_REG_W    = TAPS_PER_REG * TAP_W;
  localparam int unsigned BANK_REGS    = 2 * TAP_REGS;

  // Arithmetic widths.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = SAMPLE_W + TAP_W;
  localparam int unsigned ACC_W     = PROD_W + $clog2(WIN_DEPTH);
  localparam int unsigned Q_W       = ACC_W - FRAC_BITS;
  localparam int unsigned OUT_W     = 20;
  localparam int unsigned HALF      = WIN_DEPTH / 2;

  // Fill counter.
  localparam int unsigned CNT_W = $clog2(WIN_DEPTH + 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = TAP_REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_FIRST   = 3'd0,
    REG_LOW_MIDDLE  = 3'd1,
    REG_LOW_LAST    = 3'd2,
    REG_HIGH_FIRST  = 3'd3,
    REG_HIGH_MIDDLE = 3'd4,
    REG_HIGH_LAST   = 3'd5,
    REG_LOW_OFFSET  = 3'd6,
    REG_HIGH_OFFSET = 3'd7
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_W-1:0]    tap_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [OUT_W-1:0]    coef_t;

  // Controls from the sequencer to every cell.
  typedef struct packed {
    logic shift;  // a sample transaction was accepted
    logic load;   // that sample completes a pair: capture products
  } cell_ctrl_t;

  // Controls from the sequencer to each reduction unit.
  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } reduce_ctrl_t;

endpackage

>>> sv/dwta_stream_if.sv
interface dwta_in_if import dwta_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink (input valid, input sample, input final_sample, output ready);
endinterface

interface dwta_out_if import dwta_pkg::*; ();
  logic  valid;
  logic  ready;
  coef_t approx;
  coef_t detail;
  logic  last_pair;

  modport source (output valid, output approx, output detail, output last_pair,
                  input ready);
  modport sink (input valid, input approx, input detail, input last_pair,
                output ready);
endinterface

>>> sv/dwt_two_channel_analysis.sv
// Channel   Dir  Payload                               Transaction
// in_if     in   sample (16b signed), final_sample     valid & ready
// out_if    out  approx, detail (20b signed),          valid & ready
//                last_pair
// cfg       in   cfg_idx_i (3b), cfg_data_i (54b)      cfg_we_i
//
// One sample transaction is taken every clock cycle while the output side
// keeps up. A result is registered in turn in the cell products, the partial
// sums, then the rounded and saturated output register. Stages advance
// independently, so the input stalls only when the product stage holds a
// result that cannot move on. Reset clears the window, the fill count, the
// pair phase, all taps and offsets, and the pipeline valids.
module dwt_two_channel_analysis import dwta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dwta_in_if.sink               in_if,
  dwta_out_if.source            out_if
);

  // ---------------------------------------------------------------------
  // Configuration registers. Taps of both banks are packed three to a
  // register, tap 0 in the low bits. The offsets pick whether the oldest
  // window slot or the one after it meets the last tap.
  // ---------------------------------------------------------------------
  logic [TAP_REG_W-1:0] tap_q [BANK_REGS];
  logic                 low_off_q, high_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r < BANK_REGS; r++) begin
        tap_q[r] <= '0;
      end
      low_off_q  <= 1'b0;
      high_off_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOW_FIRST:   tap_q[0] <= cfg_data_i;
        REG_LOW_MIDDLE:  tap_q[1] <= cfg_data_i;
        REG_LOW_LAST:    tap_q[2] <= cfg_data_i;
        REG_HIGH_FIRST:  tap_q[3] <= cfg_data_i;
        REG_HIGH_MIDDLE: tap_q[4] <= cfg_data_i;
        REG_HIGH_LAST:   tap_q[5] <= cfg_data_i;
        REG_LOW_OFFSET:  low_off_q <= cfg_data_i[0];
        REG_HIGH_OFFSET: high_off_q <= cfg_data_i[0];
      endcase
    end
  end

  // Unpack the taps of each bank.
  tap_t low_tap [TAP_COUNT];
  tap_t high_tap [TAP_COUNT];

  for (genvar t = 0; t < TAP_COUNT; t++) begin : g_unpack
    assign low_tap[t]  = tap_q[t / TAPS_PER_REG][(t % TAPS_PER_REG) * TAP_W +: TAP_W];
    assign high_tap[t] = tap_q[TAP_REGS + t / TAPS_PER_REG]
                              [(t % TAPS_PER_REG) * TAP_W +: TAP_W];
  end

  // Each window slot sees the tap reversed against its position. With
  // offset zero the newest slot is unused; with offset one the oldest is.
  tap_t cell_low_tap [WIN_DEPTH];
  tap_t cell_high_tap [WIN_DEPTH];

  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_tapsel
    tap_t low_a, low_b, high_a, high_b;
    if (k < TAP_COUNT) begin : g_a
      assign low_a  = low_tap[TAP_COUNT - 1 - k];
      assign high_a = high_tap[TAP_COUNT - 1 - k];
    end else begin : g_a_zero
      assign low_a  = '0;
      assign high_a = '0;
    end
    if (k >= 1) begin : g_b
      assign low_b  = low_tap[TAP_COUNT - k];
      assign high_b = high_tap[TAP_COUNT - k];
    end else begin : g_b_zero
      assign low_b  = '0;
      assign high_b = '0;
    end
    assign cell_low_tap[k]  = low_off_q  ? low_b  : low_a;
    assign cell_high_tap[k] = high_off_q ? high_b : high_a;
  end

  // ---------------------------------------------------------------------
  // Sequencer: fill count and pair phase decide which samples emit.
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] filled_q, filled_d;
  logic             phase_q, phase_d;
  logic             in_acc, full, emit;
  logic             s1_vld_q, s2_vld_q, out_vld_q;
  logic             s1_last_q, s2_last_q, out_last_q;
  logic             rdy2, rdy3;

  assign in_acc = in_if.valid && in_if.ready;

  // The window is full after this sample if nine were already in.
  assign full = (filled_q >= CNT_W'(WIN_DEPTH - 1));
  assign emit = full && !phase_q;

  always_comb begin
    filled_d = filled_q;
    phase_d  = phase_q;
    if (in_acc) begin
      if (filled_q < CNT_W'(WIN_DEPTH)) begin
        filled_d = filled_q + CNT_W'(1);
      end
      if (full) begin
        phase_d = !phase_q;
      end
      // End of signal: the next sample starts a fresh fill.
      if (in_if.final_sample) begin
        filled_d = '0;
        phase_d  = 1'b0;
      end
    end
  end

  // Backpressure: each stage moves on when the next one is empty or moving.
  assign rdy3        = !out_vld_q || out_if.ready;
  assign rdy2        = !s2_vld_q || rdy3;
  assign in_if.ready = !s1_vld_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q  <= '0;
      phase_q   <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
      phase_q  <= phase_d;
      if (in_if.ready) begin
        s1_vld_q <= in_acc && emit;
      end
      if (rdy2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (rdy3) begin
        out_vld_q <= s2_vld_q;
      end
    end
  end

  cell_ctrl_t   cell_ctrl;
  reduce_ctrl_t red_ctrl;

  assign cell_ctrl.shift  = in_acc;
  assign cell_ctrl.load   = in_acc && emit;
  assign red_ctrl.s2_load = s1_vld_q && rdy2;
  assign red_ctrl.s3_load = s2_vld_q && rdy3;

  always_ff @(posedge clk_i) begin
    if (cell_ctrl.load) begin
      s1_last_q <= in_if.final_sample;
    end
    if (red_ctrl.s2_load) begin
      s2_last_q <= s1_last_q;
    end
    if (red_ctrl.s3_load) begin
      out_last_q <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------------
  // Row of cells: slot 0 holds the oldest sample, the new sample enters the
  // newest slot and every slot takes its newer neighbor's sample.
  // ---------------------------------------------------------------------
  sample_t cell_sample [WIN_DEPTH];
  prod_t   low_prod [WIN_DEPTH];
  prod_t   high_prod [WIN_DEPTH];

  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    sample_t feed;
    if (k == WIN_DEPTH - 1) begin : g_head
      assign feed = in_if.sample;
    end else begin : g_link
      assign feed = cell_sample[k + 1];
    end
    dwta_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .sample_i    (feed),
      .low_tap_i   (cell_low_tap[k]),
      .high_tap_i  (cell_high_tap[k]),
      .sample_o    (cell_sample[k]),
      .low_prod_o  (low_prod[k]),
      .high_prod_o (high_prod[k])
    );
  end

  // ---------------------------------------------------------------------
  // Reduction, rounding and saturation, one unit per channel.
  // ---------------------------------------------------------------------
  coef_t approx, detail;

  dwta_reduce u_low (
    .clk_i  (clk_i),
    .ctrl_i (red_ctrl),
    .prod_i (low_prod),
    .coef_o (approx)
  );

  dwta_reduce u_high (
    .clk_i  (clk_i),
    .ctrl_i (red_ctrl),
    .prod_i (high_prod),
    .coef_o (detail)
  );

  assign out_if.valid     = out_vld_q;
  assign out_if.approx    = approx;
  assign out_if.detail    = detail;
  assign out_if.last_pair = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // The fill count saturates at the window depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(WIN_DEPTH))
    else $error("fill count above window depth");

  // A final sample restarts counting and phase.
  a_final_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_if.final_sample |=> filled_q == '0 && !phase_q)
    else $error("final sample did not restart the fill");

  // After an emitting sample that is not final, the next full sample is skipped.
  a_pair_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && emit && !in_if.final_sample |=> phase_q)
    else $error("pair phase did not toggle after a result");

  // A blocked product stage keeps its result.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !rdy2 |=> s1_vld_q)
    else $error("stalled product stage lost its result");

endmodule

>>> sv/dwta_cell.sv
// One window slot: holds a sample, passes it to the older neighbor on every
// accepted transaction and forms both channel products for its slot.
module dwta_cell import dwta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  sample_t    sample_i,
  input  tap_t       low_tap_i,
  input  tap_t       high_tap_i,
  output sample_t    sample_o,
  output prod_t      low_prod_o,
  output prod_t      high_prod_o
);

  sample_t sample_q;
  prod_t   low_prod_q, high_prod_q;
  prod_t   low_prod_d, high_prod_d;

  // The product uses the sample that enters this slot, so it matches the
  // window after the shift.
  assign low_prod_d  = sample_i * low_tap_i;
  assign high_prod_d = sample_i * high_tap_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctrl_i.shift) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      low_prod_q  <= low_prod_d;
      high_prod_q <= high_prod_d;
    end
  end

  assign sample_o    = sample_q;
  assign low_prod_o  = low_prod_q;
  assign high_prod_o = high_prod_q;

endmodule

>>> sv/dwta_reduce.sv
// Sums the cell products of one channel in two registered steps, then
// rounds half up, drops the fraction and saturates.
module dwta_reduce import dwta_pkg::*; (
  input  logic         clk_i,
  input  reduce_ctrl_t ctrl_i,
  input  prod_t        prod_i [WIN_DEPTH],
  output coef_t        coef_o
);

  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0] QMAX =
    {{(Q_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [Q_W-1:0] QMIN =
    {{(Q_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

  logic signed [ACC_W-1:0] part_d [2];
  logic signed [ACC_W-1:0] part_q [2];
  logic signed [ACC_W-1:0] acc;
  logic signed [Q_W-1:0]   quot;
  coef_t                   coef_d, coef_q;

  always_comb begin
    part_d[0] = '0;
    part_d[1] = '0;
    for (int unsigned k = 0; k < WIN_DEPTH; k++) begin
      if (k < HALF) begin
        part_d[0] = part_d[0] + ACC_W'(prod_i[k]);
      end else begin
        part_d[1] = part_d[1] + ACC_W'(prod_i[k]);
      end
    end
  end

  always_comb begin
    acc  = part_q[0] + part_q[1] + ROUND;
    quot = acc[ACC_W-1:FRAC_BITS];
    if (quot > QMAX) begin
      coef_d = QMAX[OUT_W-1:0];
    end else if (quot < QMIN) begin
      coef_d = QMIN[OUT_W-1:0];
    end else begin
      coef_d = quot[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_load) begin
      part_q[0] <= part_d[0];
      part_q[1] <= part_d[1];
    end
    if (ctrl_i.s3_load) begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> tb/sv/dwta_coef_checker.sv
`timescale 1ns / 1ps

// Watches the sample and coefficient channels and the register port. It keeps
// its own model of the taps, the offsets and the sample window, and compares
// every coefficient pair that leaves the block against the oldest prediction.
module dwta_coef_checker import dwta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dwta_in_if                    in_if,
  dwta_out_if                   out_if,
  output int unsigned           error_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  typedef struct packed {
    coef_t approx;
    coef_t detail;
    logic  last_pair;
  } coef_pair_t;

  localparam longint COEF_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint COEF_MIN = -(longint'(1) <<< (OUT_W - 1));

  logic [TAP_REG_W-1:0] tap_regs [BANK_REGS];
  logic                 low_start;
  logic                 high_start;
  sample_t              window [WIN_DEPTH];
  int unsigned          fill_count;
  logic                 odd_sample;
  coef_pair_t           pending_pairs [$];
  int unsigned          errors;
  int unsigned          checked;

  function automatic tap_t tap_of(int unsigned bank, int unsigned t);
    logic [TAP_REG_W-1:0] word;
    word = tap_regs[bank * TAP_REGS + t / TAPS_PER_REG];
    return tap_t'(word >> ((t % TAPS_PER_REG) * TAP_W));
  endfunction

  // Window sample start+j meets tap TAP_COUNT-1-j, then round half up,
  // drop the fraction and clamp to the output width.
  function automatic coef_t filter_coef(int unsigned bank, logic start);
    longint acc;
    acc = longint'(1) <<< (FRAC_BITS - 1);
    for (int j = 0; j < TAP_COUNT; j++)
      acc += longint'(window[(int'(start) + j) % WIN_DEPTH]) *
             longint'(tap_of(bank, TAP_COUNT - 1 - j));
    acc = acc >>> FRAC_BITS;
    if (acc > COEF_MAX)
      acc = COEF_MAX;
    else if (acc < COEF_MIN)
      acc = COEF_MIN;
    return coef_t'(acc);
  endfunction

  task automatic check_field(string name, logic signed [OUT_W-1:0] want,
                             logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coef_pair_t want;
    if (!rst_ni) begin
      for (int i = 0; i < BANK_REGS; i++)
        tap_regs[i] = '0;
      for (int i = 0; i < WIN_DEPTH; i++)
        window[i] = '0;
      low_start  = 1'b0;
      high_start = 1'b0;
      fill_count = 0;
      odd_sample = 1'b0;
      pending_pairs.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOW_FIRST, REG_LOW_MIDDLE, REG_LOW_LAST,
          REG_HIGH_FIRST, REG_HIGH_MIDDLE, REG_HIGH_LAST: tap_regs[cfg_idx_i] = cfg_data_i;
          REG_LOW_OFFSET:  low_start  = cfg_data_i[0];
          REG_HIGH_OFFSET: high_start = cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_if.valid && out_if.ready) begin
        if (pending_pairs.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected pair, expected none, actual approx %0d detail %0d",
                   $time, out_if.approx, out_if.detail);
        end else begin
          want = pending_pairs.pop_front();
          check_field("approx", want.approx, out_if.approx);
          check_field("detail", want.detail, out_if.detail);
          check_field("last_pair", coef_t'(want.last_pair), coef_t'(out_if.last_pair));
          checked++;
        end
      end

      if (in_if.valid && in_if.ready) begin
        for (int i = 0; i + 1 < WIN_DEPTH; i++)
          window[i] = window[i + 1];
        window[WIN_DEPTH - 1] = in_if.sample;
        if (fill_count < WIN_DEPTH)
          fill_count++;
        if (fill_count == WIN_DEPTH) begin
          if (!odd_sample) begin
            want.approx    = filter_coef(0, low_start);
            want.detail    = filter_coef(1, high_start);
            want.last_pair = in_if.final_sample;
            pending_pairs.push_back(want);
          end
          odd_sample = !odd_sample;
        end
        if (in_if.final_sample) begin
          fill_count = 0;
          odd_sample = 1'b0;
        end
      end
    end
    error_count_o <= errors;
    pending_o     <= pending_pairs.size();
    checked_o     <= checked;
  end

endmodule

>>> tb/sv/tb_dwt_two_channel_analysis.sv
`timescale 1ns / 1ps

// Top of the filter bank testbench. It only generates traffic: samples on the
// input channel, back-pressure on the coefficient channel and register writes
// between phases. All prediction and comparison lives in the checker, which
// reports its error count and the number of pairs still outstanding.
module tb_dwt_two_channel_analysis;
  import dwta_pkg::*;

  // Roughly 850 samples, even if each sees a long input gap and a long output
  // stall, stay well within the limit, which leaves ample room.
  localparam int unsigned CYCLE_LIMIT   = 500000;
  // After the last expected pair, these settle cycles leave the pipeline
  // empty for register writes.
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam sample_t S_MAX   = 16'sh7fff;
  localparam sample_t S_MIN   = 16'sh8000;
  localparam tap_t    TAP_MAX = 18'sh1ffff;
  localparam tap_t    TAP_MIN = 18'sh20000;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dwta_in_if  in_ch ();
  dwta_out_if out_ch ();

  int unsigned error_count;
  int unsigned pending_pairs;
  int unsigned checked_pairs;
  int unsigned cycle_count   = 0;
  int unsigned samples_sent  = 0;
  int unsigned signals_sent  = 0;
  int unsigned settings_used = 1;
  int unsigned stall_left    = 0;
  logic        steady;

  // Tap sets for the next register load, tap 0 first.
  tap_t    low_set  [TAP_COUNT];
  tap_t    high_set [TAP_COUNT];
  sample_t edge_mix [6];

  dwt_two_channel_analysis dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  dwta_coef_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_if         (in_ch),
    .out_if        (out_ch),
    .error_count_o (error_count),
    .pending_o     (pending_pairs),
    .checked_o     (checked_pairs)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle lengths: mostly none, often a few cycles, rarely a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic sample_t pick_extreme();
    case ($urandom_range(0, 3))
      0: return S_MAX;
      1: return S_MIN;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // A quarter of the samples sit on the corners of the range, so that the
  // sums regularly come close to the saturation limits.
  function automatic sample_t random_sample();
    if ($urandom_range(0, 3) == 0)
      return pick_extreme();
    return sample_t'($urandom);
  endfunction

  // Three taps of one bank share a register, tap 0 of the group in the low bits.
  function automatic logic [TAP_REG_W-1:0] pack_taps(logic high_bank, int unsigned grp);
    logic [TAP_REG_W-1:0] word;
    for (int k = 0; k < TAPS_PER_REG; k++)
      word[k * TAP_W +: TAP_W] = high_bank ? high_set[grp * TAPS_PER_REG + k]
                                           : low_set[grp * TAPS_PER_REG + k];
    return word;
  endfunction

  // Output back-pressure. Stalls start at random and range from brief to a
  // long stretch; in steady phases no new coefficient channel stall starts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pairs outstanding", cycle_count,
               pending_pairs);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One register write per cycle; the caller lowers the write enable.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  // Loads both tap sets and both offsets. Only bit 0 of an offset register is
  // meaningful, so the upper bits carry random junk that must be ignored.
  task automatic program_filter(logic low_off, logic high_off);
    logic [CFG_DATA_W-1:0] junk;
    write_reg(REG_LOW_FIRST,   pack_taps(1'b0, 0));
    write_reg(REG_LOW_MIDDLE,  pack_taps(1'b0, 1));
    write_reg(REG_LOW_LAST,    pack_taps(1'b0, 2));
    write_reg(REG_HIGH_FIRST,  pack_taps(1'b1, 0));
    write_reg(REG_HIGH_MIDDLE, pack_taps(1'b1, 1));
    write_reg(REG_HIGH_LAST,   pack_taps(1'b1, 2));
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_LOW_OFFSET, {junk[CFG_DATA_W-1:1], low_off});
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_HIGH_OFFSET, {junk[CFG_DATA_W-1:1], high_off});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offers one sample transaction, after an optional gap, and returns in the
  // time step of the edge that accepted it. Valid stays high so that the next
  // sample can follow back to back.
  task automatic send_sample(sample_t value, logic last);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= value;
    in_ch.final_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
    if (last)
      signals_sent++;
  endtask

  // One whole signal, ended by the final-sample flag. Now and then the signal
  // holds a single extreme value, which can drive the sums into saturation.
  task automatic send_random_signal(int unsigned len);
    logic    held;
    sample_t hold_value;
    held       = ($urandom_range(0, 9) == 0);
    hold_value = pick_extreme();
    for (int unsigned i = 0; i < len; i++)
      send_sample(held ? hold_value : random_sample(), i == len - 1);
  endtask

  // Mostly signals long enough to produce pairs; some end before the window
  // fills and a few run long. The last signal is cut to fit the sample count.
  task automatic run_random(int unsigned count);
    int unsigned left;
    int unsigned len;
    int unsigned r;
    left = count;
    steady <= ($urandom_range(0, 3) == 0);
    while (left != 0) begin
      r = $urandom_range(0, 99);
      if (r < 12)
        len = $urandom_range(1, WIN_DEPTH - 1);
      else if (r < 88)
        len = $urandom_range(WIN_DEPTH, 40);
      else
        len = $urandom_range(41, 120);
      if (len > left)
        len = left;
      send_random_signal(len);
      left -= len;
    end
  endtask

  // Stops the stream and waits for every predicted pair. The first edge lets
  // the checker count the transaction just accepted; the settle cycles cover
  // samples still in the pipeline that produce no pair.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.final_sample = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    steady             = 1'b0;
    edge_mix = '{S_MAX, S_MIN, 16'sh0000, 16'shffff, 16'sh0001, 16'sh5555};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: all taps are zero, so every coefficient must be zero.
    run_random(40);

    // Textbook analysis taps in Q2.16, detail window shifted by one sample.
    drain_results();
    low_set  = '{1753, -1105, -5126, 17489, 39515, 17489, -5126, -1105, 1753};
    high_set = '{0, 5982, -3771, -38749, 73079, -38749, -3771, 5982, 0};
    program_filter(1'b0, 1'b1);

    // A signal that ends before the window fills gives no pair at all.
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(16'sh0000, 1'b1);
    // The end of a signal on a sample that skips its pair: one pair only,
    // and the fill count must restart for the next signal.
    for (int i = 0; i < 11; i++)
      send_sample(edge_mix[i % 6], i == 10);
    // The end of a signal on a pair-producing sample: the second pair carries
    // the last-pair flag.
    for (int i = 0; i < 12; i++)
      send_sample(S_MAX, i == 11);
    run_random(120);

    // Largest taps of opposite sign in the two banks: both saturation limits.
    drain_results();
    foreach (low_set[k]) begin
      low_set[k]  = TAP_MAX;
      high_set[k] = TAP_MIN;
    end
    program_filter(1'b1, 1'b1);
    run_random(120);

    drain_results();
    foreach (low_set[k]) begin
      low_set[k]  = TAP_MIN;
      high_set[k] = TAP_MAX;
    end
    program_filter(1'b0, 1'b0);
    run_random(120);

    // Alternating extremes, so each tap position is checked in its own slot.
    drain_results();
    foreach (low_set[k]) begin
      low_set[k]  = (k % 2 == 0) ? TAP_MAX : TAP_MIN;
      high_set[k] = (k % 2 == 0) ? TAP_MIN : TAP_MAX;
    end
    program_filter(1'b1, 1'b0);
    run_random(100);

    // Fully random taps and offsets.
    for (int p = 0; p < 3; p++) begin
      drain_results();
      foreach (low_set[k]) begin
        low_set[k]  = tap_t'($urandom);
        high_set[k] = tap_t'($urandom);
      end
      program_filter(1'($urandom), 1'($urandom));
      run_random(100);
    end

    drain_results();
    $display("Covered %0d samples in %0d signals, %0d coefficient pairs checked,",
             samples_sent, signals_sent, checked_pairs);
    $display("over %0d tap and offset settings with random input gaps and output stalls.",
             settings_used);
    if (error_count == 0 && pending_pairs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
